FILE: rtl/core/sphd_pkg.sv
// ----------------------------------------------------------------------------
// sphd_pkg
// shared constants and types for the cubic spline density unit
// ----------------------------------------------------------------------------
package sphd_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   // 2^30 and 2^60/pi
   localparam logic [31:0] Q_ONE      = 32'h4000_0000;
   localparam logic [63:0] INV_PI_Q60 = 64'd366986312910250154;

   // shared divider request
   typedef struct packed {
      logic          start;
      logic [127:0]  dividend;
      logic [31:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [127:0]  quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/sph_density_cubic_spline_unit.sv
// ----------------------------------------------------------------------------
// sph_density_cubic_spline_unit
// sph density summation with the 3d cubic spline kernel
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req_     in         req_valid/req_stall positions, lengths, mass, last flag
//  rsp_     out        rsp_valid/rsp_stall density, zero flag
//
//  a new word is accepted only once the previous word has left the sequencer; when
//  both kernel terms are evaluated, a word runs 3 multiply steps and 33 square root
//  steps, then per term four 128-step divisions (q, then three times by h) plus
//  sequencing and multiply steps; a term outside the support skips its divisions
//  and multiplies and contributes zero
//  reset clears the accumulator and the sequencer; a word that ends a list waits
//  in its last step while the previous density word is still held by rsp_stall
// ----------------------------------------------------------------------------
module sph_density_cubic_spline_unit #(
   parameter int FRAC_BITS = sphd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_src_x,
   input  logic signed [31:0]  req_src_y,
   input  logic signed [31:0]  req_src_z,
   input  logic [31:0]         req_src_smooth_len,
   input  logic signed [31:0]  req_nb_x,
   input  logic signed [31:0]  req_nb_y,
   input  logic signed [31:0]  req_nb_z,
   input  logic [31:0]         req_nb_smooth_len,
   input  logic [31:0]         req_nb_mass,
   input  logic                req_last_nb,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [63:0]         rsp_density,
   output logic                rsp_zero_density
);

   localparam int SHIFT = 59 - 2 * FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_SQ, S_SUM, S_ROOT, S_H, S_QDIV, S_QWAIT, S_Q2, S_Q3, S_W,
      S_T2, S_T3, S_WM, S_P0, S_P1, S_P2, S_P3, S_D1, S_D2, S_D3, S_DW,
      S_ACC
   } state_type;

   state_type    state_ff;
   logic [31:0]  dx_ff, dy_ff, dz_ff;
   logic [65:0]  sq_ff;
   logic [1:0]   idx_ff;
   logic [32:0]  root_ff;
   logic [32:0]  rem_ff;
   logic [65:0]  rad_ff;
   logic [5:0]   step_ff;
   logic [31:0]  hs_ff, hn_ff, mass_ff, h_ff;
   logic         last_ff, which_ff;
   logic [31:0]  q_ff, q2_ff, t_ff;
   logic [31:0]  w_ff;
   logic [63:0]  wm_ff;
   logic [127:0] v_ff, va_ff;
   logic [63:0]  sum_ff;
   logic         zero_term_ff;
   logic         rsp_valid_ff;
   logic [63:0]  rsp_density_ff;
   logic [2:0]   dcnt_ff;

   localparam logic [31:0] INV_LO = sphd_pkg::INV_PI_Q60[31:0];
   localparam logic [31:0] INV_HI = sphd_pkg::INV_PI_Q60[63:32];

   // shared 32x32 multiplier
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   sphd_pkg::div_req_type dreq;
   sphd_pkg::div_rsp_type drsp;

   sphd_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [34:0]  rtrial;
   logic [34:0]  rcur;
   logic [127:0] vsum;
   logic [63:0]  contrib;
   logic [63:0]  sumadd;
   logic         sumcarry;
   logic [63:0]  wa, wb;
   logic         rsp_load;

   function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({a[31], a}) - $signed({b[31], b});
      return d[32] ? 32'(-d) : d[31:0];
   endfunction

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         S_SQ:  begin
            mul_a = (idx_ff == 2'd0) ? dx_ff : (idx_ff == 2'd1) ? dy_ff : dz_ff;
            mul_b = mul_a;
         end
         S_Q2:  begin mul_a = q_ff;  mul_b = q_ff; end
         S_Q3:  begin mul_a = q2_ff; mul_b = q_ff; end
         S_T2:  begin mul_a = t_ff;  mul_b = t_ff; end
         S_T3:  begin mul_a = q2_ff; mul_b = t_ff; end
         S_WM:  begin mul_a = w_ff; mul_b = mass_ff; end
         S_P0:  begin mul_a = wm_ff[31:0];  mul_b = INV_LO; end
         S_P1:  begin mul_a = wm_ff[31:0];  mul_b = INV_HI; end
         S_P2:  begin mul_a = wm_ff[63:32]; mul_b = INV_LO; end
         S_P3:  begin mul_a = wm_ff[63:32]; mul_b = INV_HI; end
         default: ;
      endcase
   end

   // square root step: two radicand bits in, one root bit out
   assign rcur   = {rem_ff, rad_ff[65:64]};
   assign rtrial = {root_ff[32:0], 2'b01};

   // cubic polynomial pieces (q < 1 branch)
   assign wa = 64'(sphd_pkg::Q_ONE) + ((64'd3 * {32'd0, mul_p[61:30]}) >> 2);
   assign wb = (64'd3 * {32'd0, q2_ff}) >> 1;

   assign vsum = va_ff + v_ff;
   assign contrib = (vsum[127:64] >> SHIFT) != 64'd0 ? '1
                  : 64'(vsum >> SHIFT);
   assign {sumcarry, sumadd} = {1'b0, sum_ff} + {1'b0, contrib};

   // list end: load the output register once the previous word has gone
   assign rsp_load = (state_ff == S_ACC) && last_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      dreq.start    = 1'b0;
      dreq.dividend = v_ff;
      dreq.divisor  = h_ff;
      if (state_ff == S_QDIV) begin
         dreq.start    = 1'b1;
         dreq.dividend = {62'd0, root_ff, 33'd0} >> 3;
      end else if (state_ff == S_D1 || state_ff == S_D2 || state_ff == S_D3) begin
         dreq.start    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && !req_stall) begin
               dx_ff   <= absdiff(req_nb_x, req_src_x);
               dy_ff   <= absdiff(req_nb_y, req_src_y);
               dz_ff   <= absdiff(req_nb_z, req_src_z);
               hs_ff   <= req_src_smooth_len;
               hn_ff   <= req_nb_smooth_len;
               mass_ff <= req_nb_mass;
               last_ff <= req_last_nb;
               sq_ff   <= '0;
               idx_ff  <= 2'd0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               sq_ff  <= sq_ff + {2'd0, mul_p};
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd2) state_ff <= S_SUM;
            end
            S_SUM: begin
               rad_ff  <= sq_ff;
               rem_ff  <= '0;
               root_ff <= '0;
               step_ff <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               rad_ff <= {rad_ff[63:0], 2'b00};
               if (rcur >= rtrial) begin
                  rem_ff  <= 33'(rcur - rtrial);
                  root_ff <= {root_ff[31:0], 1'b1};
               end else begin
                  rem_ff  <= rcur[32:0];
                  root_ff <= {root_ff[31:0], 1'b0};
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd32) begin
                  which_ff <= 1'b0;
                  va_ff    <= '0;
                  state_ff <= S_H;
               end
            end
            S_H: begin
               h_ff <= which_ff ? hn_ff : hs_ff;
               zero_term_ff <= ({1'b0, root_ff} >= {1'b0, (which_ff ? hn_ff : hs_ff), 1'b0})
                               || ((which_ff ? hn_ff : hs_ff) == 32'd0);
               state_ff <= S_QDIV;
            end
            S_QDIV: state_ff <= zero_term_ff ? S_DW : S_QWAIT;
            S_QWAIT: if (drsp.done) begin
               q_ff     <= drsp.quotient[31:0];
               state_ff <= drsp.quotient[30] | drsp.quotient[31] ? S_T2 : S_Q2;
               t_ff     <= 32'h8000_0000 - drsp.quotient[31:0];
            end
            S_Q2: begin q2_ff <= mul_p[61:30]; state_ff <= S_Q3; end
            S_Q3: begin
               w_ff <= (wa >= wb) ? 32'(wa - wb) : '0;
               state_ff <= S_WM;
            end
            S_T2: begin q2_ff <= mul_p[61:30]; state_ff <= S_T3; end
            S_T3: begin w_ff <= {2'd0, mul_p[61:32]}; state_ff <= S_WM; end
            S_WM: begin wm_ff <= mul_p; v_ff <= '0; state_ff <= S_P0; end
            S_P0: begin v_ff <= v_ff + {64'd0, mul_p}; state_ff <= S_P1; end
            S_P1: begin v_ff <= v_ff + {32'd0, mul_p, 32'd0}; state_ff <= S_P2; end
            S_P2: begin v_ff <= v_ff + {32'd0, mul_p, 32'd0}; state_ff <= S_P3; end
            S_P3: begin
               v_ff <= v_ff + {mul_p, 64'd0};
               dcnt_ff <= 3'd0;
               state_ff <= S_D1;
            end
            S_D1, S_D2, S_D3: state_ff <= S_DW;
            S_DW: begin
               if (zero_term_ff) begin
                  v_ff <= '0;
                  dcnt_ff <= 3'd3;
               end
               if (zero_term_ff || drsp.done) begin
                  if (!zero_term_ff) v_ff <= drsp.quotient;
                  if (zero_term_ff || dcnt_ff == 3'd2) begin
                     if (which_ff) state_ff <= S_ACC;
                     else begin
                        va_ff    <= zero_term_ff ? '0 : drsp.quotient;
                        which_ff <= 1'b1;
                        state_ff <= S_H;
                     end
                  end else begin
                     dcnt_ff  <= dcnt_ff + 3'd1;
                     state_ff <= (dcnt_ff == 3'd0) ? S_D2 : S_D3;
                  end
               end
            end
            S_ACC: begin
               if (last_ff) begin
                  if (rsp_load) begin
                     rsp_density_ff <= sumcarry ? '1 : sumadd;
                     sum_ff         <= '0;
                     state_ff       <= S_IDLE;
                  end
               end else begin
                  sum_ff   <= sumcarry ? '1 : sumadd;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_density      = rsp_density_ff;
   assign rsp_zero_density = (rsp_density_ff == 64'd0);

endmodule

FILE: rtl/core/sphd_divider.sv
// ----------------------------------------------------------------------------
// sphd_divider
// radix-2 restoring divider, 128-bit dividend by 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module sphd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sphd_pkg::div_req_type req,
   output sphd_pkg::div_rsp_type rsp
);

   logic [127:0] quo_ff, quo_in;
   logic [31:0]  rem_ff, rem_in;
   logic [31:0]  dsr_ff, dsr_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [32:0]  trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[127]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = 8'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 32'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[126:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[126:0], 1'b0};
         end
         cnt_in = cnt_ff + 8'd1;
         if (cnt_ff == 8'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: sim/sph_density_checker.sv
// ----------------------------------------------------------------------------
// sph_density_checker
// watches both channels, predicts the summed density of each neighbour list
// and compares every result word with the oldest prediction still waiting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_density_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_src_x,
   input  logic signed [31:0] req_src_y,
   input  logic signed [31:0] req_src_z,
   input  logic [31:0]        req_src_smooth_len,
   input  logic signed [31:0] req_nb_x,
   input  logic signed [31:0] req_nb_y,
   input  logic signed [31:0] req_nb_z,
   input  logic [31:0]        req_nb_smooth_len,
   input  logic [31:0]        req_nb_mass,
   input  logic               req_last_nb,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [63:0]        rsp_density,
   input  logic               rsp_zero_density,
   output int                 fail_count,
   output int                 pending_count
);

   localparam int FRAC_BITS = sphd_pkg::FRAC_BITS_DEFAULT;
   localparam int TERM_SHIFT = 59 - 2 * FRAC_BITS;

   typedef struct {
      logic [63:0] density;
      logic        zero_density;
   } density_result_type;

   density_result_type expected_densities[$];
   logic [63:0]        running_density;

   function automatic logic [32:0] coord_gap(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [33:0] d;
      d = 34'(a) - 34'(b);
      return d < 0 ? 33'(-d) : 33'(d);
   endfunction

   // bit-serial floor square root of the 66-bit square sum
   function automatic logic [33:0] floor_root(logic [65:0] s);
      logic [39:0] rem;
      logic [39:0] trial;
      logic [33:0] root;
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | 40'(s[2*i +: 2]);
         trial = (40'(root) << 2) | 40'd1;
         root = root << 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root[0] = 1'b1;
         end
      end
      return root;
   endfunction

   function automatic logic [127:0] spline_term(logic [33:0] r, logic [31:0] h,
                                                logic [31:0] m);
      logic [63:0]  q, q2, q3, a, b, t, t3, w;
      logic [127:0] v;
      if (h == 0 || 35'(r) >= 35'(h) * 2) return '0;
      q = {r[33:0], 30'b0} / 64'(h);
      if (q < 64'(sphd_pkg::Q_ONE)) begin
         q2 = (q * q) >> 30;
         q3 = (q2 * q) >> 30;
         a  = 64'(sphd_pkg::Q_ONE) + ((3 * q3) >> 2);
         b  = (3 * q2) >> 1;
         w  = a >= b ? a - b : 64'd0;
      end else begin
         t  = 2 * 64'(sphd_pkg::Q_ONE) - q;
         t3 = (((t * t) >> 30) * t) >> 30;
         w  = t3 >> 2;
      end
      v = 128'(w * 64'(m)) * 128'(sphd_pkg::INV_PI_Q60);
      v = v / 128'(h);
      v = v / 128'(h);
      v = v / 128'(h);
      return v;
   endfunction

   always @(posedge clock) begin
      logic [65:0]  sq_sum;
      logic [33:0]  nb_range;
      logic [128:0] both_terms;
      logic [63:0]  contrib;
      logic [64:0]  total;
      density_result_type exp_word;
      if (reset) begin
         running_density <= '0;
         expected_densities.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            sq_sum = 66'(coord_gap(req_nb_x, req_src_x)) ** 2
                   + 66'(coord_gap(req_nb_y, req_src_y)) ** 2
                   + 66'(coord_gap(req_nb_z, req_src_z)) ** 2;
            nb_range = floor_root(sq_sum);
            both_terms = 129'(spline_term(nb_range, req_src_smooth_len, req_nb_mass))
                       + 129'(spline_term(nb_range, req_nb_smooth_len, req_nb_mass));
            if ((both_terms >> TERM_SHIFT) >> 64 != 0) contrib = '1;
            else contrib = 64'(both_terms >> TERM_SHIFT);
            total = 65'(running_density) + 65'(contrib);
            if (total[64]) total[63:0] = '1;
            if (req_last_nb) begin
               exp_word.density = total[63:0];
               exp_word.zero_density = total[63:0] == 0;
               expected_densities.push_back(exp_word);
               running_density <= '0;
            end else begin
               running_density <= total[63:0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_densities.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected density word %h zero %b", rsp_density,
                           rsp_zero_density);
               fail_count <= fail_count + 1;
            end else begin
               exp_word = expected_densities.pop_front();
               if (exp_word.density !== rsp_density ||
                   exp_word.zero_density !== rsp_zero_density) begin
                  if (fail_count < 10)
                     $display("density mismatch: expected %h zero %b, got %h zero %b",
                              exp_word.density, exp_word.zero_density,
                              rsp_density, rsp_zero_density);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_densities.size();
      end
   end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives neighbour lists into the cubic spline density unit in bursts, stalls
// the result side on its own pattern and takes the verdict from the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_WORDS = 1080;
   localparam int DRAIN_CYCLES = 3000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_src_x, req_src_y, req_src_z;
   logic [31:0]        req_src_smooth_len;
   logic signed [31:0] req_nb_x, req_nb_y, req_nb_z;
   logic [31:0]        req_nb_smooth_len;
   logic [31:0]        req_nb_mass;
   logic               req_last_nb;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [63:0]        rsp_density;
   logic               rsp_zero_density;
   int                 fail_count;
   int                 pending_count;

   // sender burst bookkeeping
   int burst_left;

   sph_density_cubic_spline_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_src_x(req_src_x), .req_src_y(req_src_y), .req_src_z(req_src_z),
      .req_src_smooth_len(req_src_smooth_len),
      .req_nb_x(req_nb_x), .req_nb_y(req_nb_y), .req_nb_z(req_nb_z),
      .req_nb_smooth_len(req_nb_smooth_len), .req_nb_mass(req_nb_mass),
      .req_last_nb(req_last_nb),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_density(rsp_density), .rsp_zero_density(rsp_zero_density)
   );

   sph_density_checker density_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_src_x(req_src_x), .req_src_y(req_src_y), .req_src_z(req_src_z),
      .req_src_smooth_len(req_src_smooth_len),
      .req_nb_x(req_nb_x), .req_nb_y(req_nb_y), .req_nb_z(req_nb_z),
      .req_nb_smooth_len(req_nb_smooth_len), .req_nb_mass(req_nb_mass),
      .req_last_nb(req_last_nb),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_density(rsp_density), .rsp_zero_density(rsp_zero_density),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: time for every word plus gaps and stalls, taken about six times over
   initial begin
      #(12 * 8_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side stall pattern: free running, coin flips, or long holds,
   // with the mode and its length drawn anew at random each time it runs out
   initial begin
      int mode, mode_left, hold;
      rsp_stall = 1'b0;
      mode = 0;
      mode_left = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(100, 600);
         end
         mode_left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 1);
            default: begin
               if (hold == 0) hold = $urandom_range(1, 40);
               hold--;
               rsp_stall <= hold > $urandom_range(0, 20);
            end
         endcase
      end
   end

   // present one word and hold it until taken; a gap may follow the word
   task automatic send_word(logic signed [31:0] sx, sy, sz, logic [31:0] sh,
                            logic signed [31:0] nx, ny, nz, logic [31:0] nh,
                            logic [31:0] mass, logic last);
      int gap;
      req_valid <= 1'b1;
      req_src_x <= sx; req_src_y <= sy; req_src_z <= sz;
      req_src_smooth_len <= sh;
      req_nb_x <= nx; req_nb_y <= ny; req_nb_z <= nz;
      req_nb_smooth_len <= nh;
      req_nb_mass <= mass;
      req_last_nb <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // send a list of neighbours around one source particle; most lie inside
   // the kernel support, a few are scattered anywhere
   task automatic send_list(int count);
      logic signed [31:0] sx, sy, sz;
      logic [31:0]        sh, nh, span, mass;
      sx = $urandom; sy = $urandom; sz = $urandom;
      case ($urandom_range(0, 5))
         0:       sh = $urandom_range(1, 32'hffff_ffff);
         1:       sh = $urandom_range(1, 16);
         default: sh = $urandom_range(32'h0000_4000, 32'h0008_0000);
      endcase
      for (int i = 0; i < count; i++) begin
         nh = $urandom_range(0, 2) == 0 ? $urandom_range(1, 32'hffff_ffff)
                                       : sh + $urandom_range(0, sh >> 2);
         if (nh == 0) nh = 1;
         span = sh > 32'h3fff_ffff ? 32'h7fff_ffff : sh << 1;
         mass = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
         if ($urandom_range(0, 9) == 0)
            send_word(sx, sy, sz, sh, $urandom, $urandom, $urandom, nh, mass,
                      i == count - 1);
         else
            send_word(sx, sy, sz, sh,
                      sx + $signed($urandom_range(0, span)) - $signed(span >> 1),
                      sy + $signed($urandom_range(0, span)) - $signed(span >> 1),
                      sz + $signed($urandom_range(0, span)) - $signed(span >> 1),
                      nh, mass, i == count - 1);
      end
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_src_x = '0; req_src_y = '0; req_src_z = '0;
      req_src_smooth_len = 32'h0001_0000;
      req_nb_x = '0; req_nb_y = '0; req_nb_z = '0;
      req_nb_smooth_len = 32'h0001_0000;
      req_nb_mass = '0;
      req_last_nb = 1'b0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // coincident particles, unit length and mass: full kernel value
      send_word(0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1);
      // lone neighbour far outside support gives a zero density
      send_word(0, 0, 0, 32'h0001_0000, 32'h0010_0000, 0, 0, 32'h0001_0000,
                32'h0001_0000, 1);
      // zero mass at zero distance
      send_word(5, 5, 5, 32'h0002_0000, 5, 5, 5, 32'h0002_0000, 0, 1);
      // inner branch, outer branch, edge just inside and on 2h
      send_word(0, 0, 0, 32'h0001_0000, 32'h0000_8000, 0, 0, 32'h0001_0000,
                32'h0003_0000, 0);
      send_word(0, 0, 0, 32'h0001_0000, 0, 32'h0001_8000, 0, 32'h0001_0000,
                32'h0003_0000, 0);
      send_word(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_ffff, 32'h0001_0000,
                32'h0003_0000, 0);
      send_word(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000, 32'h0001_0000,
                32'h0003_0000, 0);
      // q exactly one, then different lengths on each side
      send_word(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000,
                32'h0001_0000, 0);
      send_word(-100, 7, 3, 32'h0000_4000, -100, 7, 32'h0000_6000, 32'h0004_0000,
                32'h0002_0000, 1);
      // position extremes on every axis, largest lengths
      send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hffff_ffff,
                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 1);
      send_word(32'sh7fff_ffff, 32'sh8000_0000, 0, 32'hffff_ffff,
                32'sh7fff_ffff, 32'sh8000_0000, 0, 32'h0000_0001, 32'hffff_ffff, 1);
      // tiny lengths with heavy mass: contribution and sum saturate
      send_word(0, 0, 0, 32'h0000_0001, 0, 0, 0, 32'h0000_0001, 32'hffff_ffff, 0);
      send_word(0, 0, 0, 32'h0000_0002, 1, 0, 0, 32'h0000_0003, 32'hffff_ffff, 0);
      send_word(0, 0, 0, 32'h0000_0100, 0, 0, 0, 32'h0000_0100, 32'hffff_ffff, 1);
      // single-bit distance, zero distance with one far length
      send_word(0, 0, 0, 32'h0000_0001, 1, 0, 0, 32'h0000_0001, 32'h0001_0000, 1);
      send_word(-1, -1, -1, 32'h8000_0000, -1, -1, -1, 32'h0000_0001,
                32'h8000_0000, 1);

      // random lists; one pause halfway lets every result drain first
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         int len;
         len = $urandom_range(0, 9) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 6);
         send_list(len);
         sent += len;
         if (sent >= RANDOM_WORDS / 2 && sent - len < RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            while (pending_count != 0) @(posedge clock);
            @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
